@@ hw/rtl/isf_pkg.sv @@
// Package for the image standardization core: field widths, status codes,
// request and result item types and the state encodings of the front and back.
// No dependencies.
`default_nettype none

package isf_pkg;

   localparam int unsigned INDEX_BITS  = 11;
   localparam int unsigned PIXEL_BITS  = 8;
   localparam int unsigned VALUE_BITS  = 10;
   localparam int unsigned STATUS_BITS = 2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_NO_IMAGE  = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef struct packed {
      logic                  req_type;
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last;
      logic [INDEX_BITS-1:0] index;
   } isf_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [INDEX_BITS-1:0]        position;
      logic [STATUS_BITS-1:0]       status;
   } isf_rsp_type;

   typedef enum logic [1:0] {
      FR_IDLE = 2'd0,
      FR_MUL  = 2'd1,
      FR_VAR  = 2'd2
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'd0,
      BK_MUL  = 3'd1,
      BK_SQR  = 3'd2,
      BK_CHK  = 3'd3,
      BK_DIV  = 3'd4,
      BK_ROOT = 3'd5,
      BK_OUT  = 3'd6
   } back_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/isf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module isf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/isf_queue.sv @@
// Small FIFO that carries classified read jobs from the front to the back.
// No dependencies.
`default_nettype none

module isf_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  din,
   input  wire              pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty,
   output logic             full
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [NW-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = NW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = NW'(cnt_ff - 1'b1);
      end
   end

   assign dout  = slot_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == NW'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/isf_front.sv @@
// Front of the standardization core: takes items, stores pixels, keeps the
// running statistics, closes images and classifies reads. Uses isf_pkg.
`default_nettype none

module isf_front #(
   parameter int unsigned MAX_PIXELS = 2048
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  isf_pkg::isf_req_type         req_item,
   output logic                         busy,
   output logic                         ram_we,
   output logic [$clog2(MAX_PIXELS)-1:0] ram_waddr,
   output logic [isf_pkg::PIXEL_BITS-1:0] ram_wdata,
   output logic [$clog2(MAX_PIXELS)-1:0] ram_raddr,
   input  wire  [isf_pkg::PIXEL_BITS-1:0] ram_rdata,
   input  wire                          q_full,
   output logic                         q_push,
   output logic [isf_pkg::INDEX_BITS + isf_pkg::STATUS_BITS + isf_pkg::PIXEL_BITS
                 + 4*$clog2(MAX_PIXELS+1) + 3*isf_pkg::PIXEL_BITS - 1:0] q_din
);

   import isf_pkg::*;

   localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
   localparam int unsigned SW = CW + PIXEL_BITS;
   localparam int unsigned QW = CW + 2*PIXEL_BITS;
   localparam int unsigned VW = CW + QW;
   localparam int unsigned AW = $clog2(MAX_PIXELS);
   localparam int unsigned XW = (INDEX_BITS > CW) ? INDEX_BITS : CW;

   front_state_type state_ff, state_in;

   logic [CW-1:0] run_cnt_ff;
   logic [SW-1:0] run_sum_ff;
   logic [QW-1:0] run_sq_ff;
   logic [CW-1:0] fin_cnt_ff;
   logic [SW-1:0] fin_sum_ff;
   logic [QW-1:0] fin_sq_ff;
   logic [VW-1:0] nq_ff;
   logic [VW-1:0] ss_ff;
   logic [CW-1:0] img_cnt_ff;
   logic [SW-1:0] img_sum_ff;
   logic [VW-1:0] var_ff;
   logic          ready_ff;
   logic          rd_pend_ff;
   logic [INDEX_BITS-1:0]  rd_idx_ff;
   logic [STATUS_BITS-1:0] rd_status_ff, rd_status_in;

   logic          load_acc;
   logic          read_acc;
   logic          room;
   logic [CW-1:0] new_cnt;
   logic [SW-1:0] new_sum;
   logic [QW-1:0] new_sq;
   logic [XW-1:0] idx_ext;
   logic [VW-1:0] var_diff;
   logic [VW-1:0] var_new;
   logic          fin_done;

   assign load_acc = start && !busy && (req_item.req_type == REQ_LOAD);
   assign read_acc = start && !busy && (req_item.req_type == REQ_READ);
   assign room     = (run_cnt_ff < CW'(MAX_PIXELS));
   assign idx_ext  = XW'(req_item.index);

   always_comb begin
      new_cnt = run_cnt_ff;
      new_sum = run_sum_ff;
      new_sq  = run_sq_ff;
      if (room) begin
         new_cnt = CW'(run_cnt_ff + 1'b1);
         new_sum = SW'(run_sum_ff + SW'(req_item.pixel));
         new_sq  = QW'(run_sq_ff + QW'(req_item.pixel * req_item.pixel));
      end
   end

   always_comb begin
      var_diff = (nq_ff > ss_ff) ? VW'(nq_ff - ss_ff) : '0;
      var_new  = (var_diff < VW'(fin_cnt_ff)) ? VW'(fin_cnt_ff) : var_diff;
   end

   always_comb begin
      if (!ready_ff) begin
         rd_status_in = ST_NO_IMAGE;
      end else if (idx_ext >= XW'(img_cnt_ff)) begin
         rd_status_in = ST_BAD_INDEX;
      end else begin
         rd_status_in = ST_OK;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (load_acc && req_item.last) begin
               state_in = FR_MUL;
            end
         end
         FR_MUL:  state_in = FR_VAR;
         FR_VAR:  state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      busy      = (state_ff != FR_IDLE) || rd_pend_ff || q_full;
      ram_we    = load_acc && room;
      ram_waddr = run_cnt_ff[AW-1:0];
      ram_wdata = req_item.pixel;
      ram_raddr = idx_ext[AW-1:0];
      q_push    = rd_pend_ff;
      fin_done  = (state_ff == FR_VAR);
   end

   assign q_din = {rd_idx_ff, rd_status_ff, ram_rdata, img_cnt_ff, img_sum_ff, var_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_IDLE;
         run_cnt_ff <= '0;
         run_sum_ff <= '0;
         run_sq_ff  <= '0;
         img_cnt_ff <= '0;
         img_sum_ff <= '0;
         var_ff     <= '0;
         ready_ff   <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= read_acc;
         if (load_acc) begin
            ready_ff <= 1'b0;
            if (req_item.last) begin
               run_cnt_ff <= '0;
               run_sum_ff <= '0;
               run_sq_ff  <= '0;
            end else begin
               run_cnt_ff <= new_cnt;
               run_sum_ff <= new_sum;
               run_sq_ff  <= new_sq;
            end
         end
         if (fin_done) begin
            img_cnt_ff <= fin_cnt_ff;
            img_sum_ff <= fin_sum_ff;
            var_ff     <= var_new;
            ready_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && req_item.last) begin
         fin_cnt_ff <= new_cnt;
         fin_sum_ff <= new_sum;
         fin_sq_ff  <= new_sq;
      end
      if (state_ff == FR_MUL) begin
         nq_ff <= VW'(fin_cnt_ff * fin_sq_ff);
         ss_ff <= VW'(fin_sum_ff * fin_sum_ff);
      end
      if (read_acc) begin
         rd_idx_ff    <= req_item.index;
         rd_status_ff <= rd_status_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/isf_back.sv @@
// Back of the standardization core: runs one read job at a time through a
// restoring divider and a bit-by-bit square root. Uses isf_pkg.
`default_nettype none

module isf_back #(
   parameter int unsigned MAX_PIXELS = 2048,
   parameter int unsigned FRAC_BITS  = 5
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_empty,
   input  wire [isf_pkg::INDEX_BITS + isf_pkg::STATUS_BITS + isf_pkg::PIXEL_BITS
                + 4*$clog2(MAX_PIXELS+1) + 3*isf_pkg::PIXEL_BITS - 1:0] q_dout,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output isf_pkg::isf_rsp_type rsp_item
);

   import isf_pkg::*;

   localparam int unsigned CW   = $clog2(MAX_PIXELS + 1);
   localparam int unsigned SW   = CW + PIXEL_BITS;
   localparam int unsigned QW   = CW + 2*PIXEL_BITS;
   localparam int unsigned VW   = CW + QW;
   localparam int unsigned QB   = 2*VALUE_BITS;
   localparam int unsigned RW   = 2*SW + 2*FRAC_BITS;
   localparam int unsigned DVW  = VW + QB;
   localparam int unsigned CMPW = (RW > DVW) ? RW : DVW;
   localparam int unsigned SCW  = $clog2(QB);
   localparam logic [VALUE_BITS-1:0] NEG_CAP = VALUE_BITS'(1) << (VALUE_BITS - 1);
   localparam logic [VALUE_BITS-1:0] POS_CAP = NEG_CAP - 1'b1;

   back_state_type state_ff, state_in;

   logic [INDEX_BITS-1:0]  e_idx;
   logic [STATUS_BITS-1:0] e_status;
   logic [PIXEL_BITS-1:0]  e_pixel;
   logic [CW-1:0]          e_cnt;
   logic [SW-1:0]          e_sum;
   logic [VW-1:0]          e_var;

   logic [INDEX_BITS-1:0]  pos_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic [PIXEL_BITS-1:0]  pix_ff;
   logic [CW-1:0]          cnt_ff;
   logic [SW-1:0]          sum_ff;
   logic [VW-1:0]          var_ff;
   logic [SW-1:0]          d_ff;
   logic                   neg_ff;
   logic [CMPW-1:0]        rem_ff;
   logic [CMPW-1:0]        dv_ff;
   logic [QB-1:0]          q_ff;
   logic [VALUE_BITS-1:0]  m_ff;
   logic [SCW-1:0]         step_ff;
   logic                   rsp_valid_ff;
   isf_rsp_type            rsp_ff;

   logic [SW-1:0]         nx;
   logic [2*SW-1:0]       d_sq;
   logic                  sat;
   logic                  div_ge;
   logic [VALUE_BITS-1:0] t;
   logic [QB-1:0]         t_sq;
   logic                  fits;
   logic [VALUE_BITS-1:0] mag;

   assign {e_idx, e_status, e_pixel, e_cnt, e_sum, e_var} = q_dout;

   always_comb begin
      nx     = SW'(cnt_ff * pix_ff);
      d_sq   = d_ff * d_ff;
      sat    = rem_ff >= (CMPW'(var_ff) << QB);
      div_ge = rem_ff >= dv_ff;
      t      = m_ff | (VALUE_BITS'(1) << step_ff);
      t_sq   = QB'(t * t);
      fits   = t_sq <= q_ff;
      if (neg_ff) begin
         mag = (m_ff > NEG_CAP) ? NEG_CAP : m_ff;
      end else begin
         mag = (m_ff > POS_CAP) ? POS_CAP : m_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (e_status != ST_OK) ? BK_OUT : BK_MUL;
            end
         end
         BK_MUL:  state_in = BK_SQR;
         BK_SQR:  state_in = BK_CHK;
         BK_CHK:  state_in = sat ? BK_ROOT : BK_DIV;
         BK_DIV:  state_in = (step_ff == '0) ? BK_ROOT : BK_DIV;
         BK_ROOT: state_in = (step_ff == '0) ? BK_OUT : BK_ROOT;
         BK_OUT:  state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      q_pop     = (state_ff == BK_IDLE) && !q_empty;
      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == BK_OUT);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            pos_ff    <= e_idx;
            status_ff <= e_status;
            pix_ff    <= e_pixel;
            cnt_ff    <= e_cnt;
            sum_ff    <= e_sum;
            var_ff    <= e_var;
            m_ff      <= '0;
            neg_ff    <= 1'b0;
         end
         BK_MUL: begin
            neg_ff <= nx < sum_ff;
            d_ff   <= (nx < sum_ff) ? SW'(sum_ff - nx) : SW'(nx - sum_ff);
         end
         BK_SQR: begin
            rem_ff <= CMPW'(d_sq) << (2*FRAC_BITS);
         end
         BK_CHK: begin
            // A quotient beyond the root range saturates the root search.
            q_ff <= sat ? '1 : '0;
            dv_ff   <= CMPW'(var_ff) << (QB - 1);
            step_ff <= sat ? SCW'(VALUE_BITS - 1) : SCW'(QB - 1);
            m_ff    <= '0;
         end
         BK_DIV: begin
            if (div_ge) begin
               rem_ff        <= CMPW'(rem_ff - dv_ff);
               q_ff[step_ff] <= 1'b1;
            end
            dv_ff   <= dv_ff >> 1;
            step_ff <= (step_ff == '0) ? SCW'(VALUE_BITS - 1) : SCW'(step_ff - 1'b1);
         end
         BK_ROOT: begin
            if (fits) begin
               m_ff <= t;
            end
            step_ff <= SCW'(step_ff - 1'b1);
         end
         BK_OUT: begin
            rsp_ff.value    <= neg_ff ? VALUE_BITS'('0 - mag) : mag;
            rsp_ff.position <= pos_ff;
            rsp_ff.status   <= status_ff;
         end
         default: begin
         end
      endcase
   end

   a_out_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_OUT |=> rsp_valid_ff)
      else $error("result strobe missing after output state");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == BK_IDLE)
      else $error("result strobe while a job is still running");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.value == '0)
      else $error("error result carries a nonzero value");

   a_root_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ROOT |=> state_ff == BK_ROOT || state_ff == BK_OUT)
      else $error("root search left early");

endmodule

`default_nettype wire

@@ hw/rtl/image_standardize_fixed_core.sv @@
// Per-image standardization core: loads the pixels of one image and returns
// standardized fixed-point elements on request.
// Uses isf_pkg, isf_ram, isf_queue, isf_front and isf_back.
//
// Usage: an item on req_item is taken at a clock edge where start is high and
// busy is low. A load item (req_type 0), while the store has room, stores one
// pixel and updates the running count, sum and sum of squares; the load marked
// last closes the image, which keeps busy high while the variance term is formed
// (states FR_MUL and FR_VAR). A read item (req_type 1) gives exactly one result
// on rsp_item, marked by a one-cycle rsp_valid strobe; loads give none.
// A load that does not close an image does not raise busy. A read keeps busy
// high while its pixel is read from the store and then waits in a two-entry
// job queue. The back runs one job at a time: a pop, setup in BK_MUL, BK_SQR
// and BK_CHK, a restoring divide, a root search and an output state. The divide
// is skipped when the quotient is out of root range, and an error read goes
// from the pop straight to the output state. While the queue is full, busy
// stays high. Reset clears the running statistics, the image statistics that
// reads use and the finished-image flag; the pixel store is not cleared. The
// receiver cannot hold results off.
`default_nettype none

module image_standardize_fixed_core #(
   parameter int unsigned MAX_PIXELS = 2048,
   parameter int unsigned FRAC_BITS  = 5
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  isf_pkg::isf_req_type req_item,
   output logic                 busy,
   output logic                 rsp_valid,
   output isf_pkg::isf_rsp_type rsp_item
);

   import isf_pkg::*;

   localparam int unsigned CW  = $clog2(MAX_PIXELS + 1);
   localparam int unsigned AW  = $clog2(MAX_PIXELS);
   localparam int unsigned ENW = INDEX_BITS + STATUS_BITS + PIXEL_BITS + 4*CW + 3*PIXEL_BITS;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [PIXEL_BITS-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [PIXEL_BITS-1:0] ram_rdata;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_empty;
   logic                  q_full;
   logic [ENW-1:0]        q_din;
   logic [ENW-1:0]        q_dout;

   isf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   isf_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_din     (q_din)
   );

   isf_queue #(
      .WIDTH (ENW),
      .DEPTH (2)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty),
      .full  (q_full)
   );

   isf_back #(
      .MAX_PIXELS (MAX_PIXELS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_dout    (q_dout),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

@@ bench/image_standardize_fixed_core_tb.sv @@
// Self-checking bench for image_standardize_fixed_core: loads images, reads back
// standardized elements and compares each result with an in-bench prediction.
// Depends on isf_pkg and the core RTL.
`default_nettype none

module image_standardize_fixed_core_tb;
   import isf_pkg::*;

   localparam int unsigned NPIX      = 2048;
   localparam int unsigned FRAC      = 5;
   localparam longint     CYCLE_CAP = 3000000;

   logic        clock;
   logic        reset;
   logic        start;
   isf_req_type req_item;
   logic        busy;
   logic        rsp_valid;
   isf_rsp_type rsp_item;

   image_standardize_fixed_core #(.MAX_PIXELS(NPIX), .FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   isf_req_type pending_items[$];
   isf_rsp_type expected_rsps[$];
   int          failures;
   int          items_taken;
   longint      cycle_count;

   // Predictor state of the core.
   logic [7:0]      px_mem[NPIX];
   longint unsigned run_sum, run_sq, run_cnt;
   longint unsigned img_sum, img_cnt, img_var;
   bit              img_ready;

   function automatic longint unsigned root_search(longint unsigned lim);
      longint unsigned m, t;
      m = 0;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
         t = m | (64'd1 << b);
         if (t * t <= lim) m = t;
      end
      return m;
   endfunction

   task automatic predict_standardize(input isf_req_type it);
      longint unsigned nq, ss, v, nx, d, r, m;
      bit              neg;
      isf_rsp_type     o;
      if (it.req_type == REQ_LOAD) begin
         img_ready = 0;
         if (run_cnt < NPIX) begin
            px_mem[run_cnt] = it.pixel;
            run_sum += it.pixel;
            run_sq  += it.pixel * it.pixel;
            run_cnt++;
         end
         if (it.last) begin
            nq = run_cnt * run_sq;
            ss = run_sum * run_sum;
            v  = (nq > ss) ? nq - ss : 0;
            if (v < run_cnt) v = run_cnt;
            img_sum = run_sum;
            img_cnt = run_cnt;
            img_var = v;
            img_ready = 1;
            run_sum = 0;
            run_sq  = 0;
            run_cnt = 0;
         end
         return;
      end
      o.position = it.index;
      o.value    = '0;
      if (!img_ready) begin
         o.status = ST_NO_IMAGE;
      end else if (it.index >= img_cnt) begin
         o.status = ST_BAD_INDEX;
      end else begin
         nx  = img_cnt * px_mem[it.index];
         neg = nx < img_sum;
         d   = neg ? img_sum - nx : nx - img_sum;
         r   = (d * d) << (2 * FRAC);
         v   = (img_var != 0) ? img_var : 1;
         m   = root_search(r / v);
         if (neg) begin
            if (m > 512) m = 512;
            o.value = -$signed({1'b0, m[9:0]});
         end else begin
            if (m > 511) m = 511;
            o.value = m[9:0];
         end
         o.status = ST_OK;
      end
      expected_rsps.push_back(o);
   endtask

   task automatic queue_load(input logic [7:0] px, input logic lst);
      isf_req_type it;
      it.req_type = REQ_LOAD;
      it.pixel    = px;
      it.last     = lst;
      it.index    = $urandom_range(2047);
      pending_items.push_back(it);
   endtask

   task automatic queue_read(input int unsigned idx);
      isf_req_type it;
      it.req_type = REQ_READ;
      it.pixel    = $urandom_range(255);
      it.last     = $urandom_range(1);
      it.index    = idx;
      pending_items.push_back(it);
   endtask

   // Shape 0: random pixels; 1: flat dark image with one bright outlier;
   // 2: flat bright image with one dark outlier.
   task automatic queue_image(input int unsigned n, input int shape);
      logic [7:0] px;
      for (int unsigned k = 0; k < n; k++) begin
         case (shape)
            1: px = (k == n / 2) ? 8'd255 : 8'd0;
            2: px = (k == n / 2) ? 8'd0 : 8'd255;
            default: px = $urandom_range(255);
         endcase
         queue_load(px, k == n - 1);
         if (k < n - 1 && $urandom_range(99) < 3) queue_read($urandom_range(2047));
      end
   endtask

   // Size of the image most recently queued, found by scanning back from the
   // tail to its closing load; reads aimed below it are in range.
   function automatic int unsigned img_cnt_hint();
      int unsigned cnt;
      int          k;
      cnt = 0;
      k = pending_items.size() - 1;
      while (k >= 0 && !(pending_items[k].req_type == REQ_LOAD && pending_items[k].last))
         k--;
      if (k < 0) return 1;
      k--;
      cnt = 1;
      while (k >= 0 && !(pending_items[k].req_type == REQ_LOAD && pending_items[k].last)) begin
         if (pending_items[k].req_type == REQ_LOAD) cnt++;
         k--;
      end
      return (cnt > NPIX) ? NPIX : cnt;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Driver: hold an item until taken, idle at a rate set by the phase.
   always @(posedge clock) begin
      int  idle_pct;
      bit  taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            predict_standardize(req_item);
            items_taken = items_taken + 1;
         end
         if (!start || taken) begin
            case ((items_taken / 400) % 4)
               1:       idle_pct = 73;
               2:       idle_pct = 36;
               default: idle_pct = 0;
            endcase
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_item <= pending_items.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe is a result that must match the oldest expectation.
   always @(posedge clock) begin
      isf_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: value %0d position %0d status %0d",
                   rsp_item.value, rsp_item.position, rsp_item.status);
            failures = failures + 1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_item.value !== e.value) begin
               $error("value: expected %0d actual %0d", e.value, rsp_item.value);
               failures = failures + 1;
            end
            if (rsp_item.position !== e.position) begin
               $error("position: expected %0d actual %0d", e.position, rsp_item.position);
               failures = failures + 1;
            end
            if (rsp_item.status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_item.status);
               failures = failures + 1;
            end
         end
      end
   end

   initial begin
      int          r;
      failures    = 0;
      items_taken = 0;
      cycle_count = 0;
      run_sum = 0; run_sq = 0; run_cnt = 0;
      img_sum = 0; img_cnt = 0; img_var = 0; img_ready = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;

      // A read before any image is closed has nothing to work on.
      queue_read(5);
      queue_image(20, 0);
      queue_read(0);
      queue_read(19);
      queue_read(20);
      queue_read(2047);
      // Loading a new image withdraws the finished one.
      queue_load(8'd255, 1'b0);
      queue_read(0);
      queue_load(8'd0, 1'b1);
      queue_read(0);
      queue_read(1);
      queue_read(2);
      queue_read(2047);
      // A single pixel and a flat image both hit the variance floor.
      queue_load(8'd0, 1'b1);
      queue_read(0);
      queue_read(1);
      for (int k = 0; k < 4; k++) queue_load(8'd128, k == 3);
      queue_read(3);
      queue_read(4);
      // Outlier images drive the value into both clamps.
      queue_image(300, 1);
      queue_read(150);
      queue_read(0);
      queue_image(300, 2);
      queue_read(150);
      queue_read(299);

      while (pending_items.size() < 1100) begin
         r = $urandom_range(99);
         if (r < 3) begin
            queue_image(280 + $urandom_range(40), 1 + $urandom_range(1));
         end else begin
            queue_image(r < 10 ? 1 : 1 + $urandom_range(r < 60 ? 8 : 40), 0);
         end
         for (int k = $urandom_range(1, 8); k > 0; k--) begin
            if ($urandom_range(99) < 85) begin
               queue_read($urandom_range(img_cnt_hint() - 1));
            end else begin
               queue_read($urandom_range(2047));
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || start) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/isf_pkg.sv
hw/rtl/isf_ram.sv
hw/rtl/isf_queue.sv
hw/rtl/isf_front.sv
hw/rtl/isf_back.sv
hw/rtl/image_standardize_fixed_core.sv
bench/image_standardize_fixed_core_tb.sv
